@@ src/wgf_pkg.sv @@
// ----------------------------------------------------------------------------
// wgf_pkg
// Shared types, constants and helpers of the white gap fill filter.
// ----------------------------------------------------------------------------
package wgf_pkg;

  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CHAN_W         = 8;
  localparam int COL_W          = 12;
  localparam int OUT_ROW_W      = 10;
  localparam int CFG_DATA_W     = 13;
  localparam int WIDTH_W        = 13;
  localparam int HEIGHT_W       = 11;
  localparam int SUM_W          = 10;
  localparam logic [SUM_W-1:0] WHITE_SUM = 10'd765;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 13'd256;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd256;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN  = 13'd3;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 13'd4096;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // handoff from the fill stage to the output buffer
  typedef struct packed {
    logic                 has_fill;   // finished pixel of the previous column
    logic                 has_self;   // last column: the pixel itself follows
    pixel_t               fill_px;
    pixel_t               self_px;
    logic [COL_W-1:0]     col;        // column of the incoming pixel
    logic [OUT_ROW_W-1:0] row;
  } load_t;

  function automatic logic is_white(input pixel_t p);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
    return s == WHITE_SUM;
  endfunction

  // white left over after the fill goes out as black
  function automatic pixel_t grounded(input pixel_t p);
    return is_white(p) ? pixel_t'(0) : p;
  endfunction

endpackage

@@ src/wgf_position.sv @@
// ----------------------------------------------------------------------------
// wgf_position
// Frame size registers and the column/row position of the next input item.
// ----------------------------------------------------------------------------
module wgf_position #(
  parameter int MAX_HEIGHT = wgf_pkg::MAX_HEIGHT_DEF,
  parameter int AW         = $clog2(MAX_HEIGHT)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wgf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_fire,
  output logic [wgf_pkg::COL_W-1:0]      col,
  output logic [AW-1:0]                  row,
  output logic [AW-1:0]                  next_row,
  output logic                           interior,
  output logic                           last_col
);

  localparam logic [wgf_pkg::WIDTH_W-1:0] HMAX = wgf_pkg::WIDTH_W'(MAX_HEIGHT);

  logic [wgf_pkg::WIDTH_W-1:0]  image_width;
  logic [wgf_pkg::HEIGHT_W-1:0] image_height;
  logic [wgf_pkg::WIDTH_W-1:0]  eff_w, eff_h, h_ext, col_inc, row_inc;
  logic                         last_row;

  always_comb begin
    h_ext = wgf_pkg::WIDTH_W'(image_height);
    if (image_width < wgf_pkg::WIDTH_MIN) begin
      eff_w = wgf_pkg::WIDTH_MIN;
    end else if (image_width > wgf_pkg::WIDTH_MAX) begin
      eff_w = wgf_pkg::WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
    if (h_ext < wgf_pkg::WIDTH_MIN) begin
      eff_h = wgf_pkg::WIDTH_MIN;
    end else if (h_ext > HMAX) begin
      eff_h = HMAX;
    end else begin
      eff_h = h_ext;
    end
    col_inc  = wgf_pkg::WIDTH_W'(col) + 1'b1;
    row_inc  = wgf_pkg::WIDTH_W'(row) + 1'b1;
    last_col = col_inc >= eff_w;
    last_row = row_inc >= eff_h;
    next_row = last_row ? '0 : row + 1'b1;
    // pixel (col-1, row) has all four neighbours inside the frame
    interior = (col >= wgf_pkg::COL_W'(2)) && (row != '0) && ((row_inc + 1'b1) <= eff_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wgf_pkg::WIDTH_RESET;
      image_height <= wgf_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      case (wgf_pkg::cfg_reg_t'(cfg_index))
        wgf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        wgf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[wgf_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      row <= next_row;
      if (last_row) begin
        col <= last_col ? '0 : wgf_pkg::COL_W'(col_inc);
      end
    end
  end

endmodule

@@ src/wgf_fill_core.sv @@
// ----------------------------------------------------------------------------
// wgf_fill_core
// Column stores and the fill stage: reads neighbours, decides the fill,
// writes the updated pixel back to the older column store.
// ----------------------------------------------------------------------------
module wgf_fill_core #(
  parameter int MAX_HEIGHT = wgf_pkg::MAX_HEIGHT_DEF,
  parameter int AW         = $clog2(MAX_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wgf_pkg::pixel_t           in_px,
  input  logic [wgf_pkg::COL_W-1:0] col,
  input  logic [AW-1:0]             row,
  input  logic [AW-1:0]             next_row,
  input  logic                      interior,
  input  logic                      last_col,
  input  logic                      out_free,
  output logic                      load,
  output wgf_pkg::load_t            load_data
);

  wgf_pkg::pixel_t newer_mem [MAX_HEIGHT];  // original pixels, previous column
  wgf_pkg::pixel_t older_mem [MAX_HEIGHT];  // updated pixels, two columns back

  wgf_pkg::pixel_t down_q, cur_u, left_q, above, s1_px, u;
  logic [wgf_pkg::COL_W-1:0] s1_col;
  logic [AW-1:0]             s1_row;
  logic                      s1_valid, s1_interior, s1_last_col, s1_move, in_fire;
  logic                      fill;
  logic [wgf_pkg::SUM_W-1:0] red_sum;
  logic [wgf_pkg::CHAN_W-1:0] avg;

  assign in_fire  = in_valid && in_ready;
  assign s1_move  = s1_valid && ((s1_col == '0) || out_free);
  assign in_ready = !s1_valid || s1_move;

  // down_q is newer[row+1] of the item in stage 1; the item before read
  // newer[row] the same way, and that value sits in cur_u.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      newer_mem[row] <= in_px;
      down_q         <= newer_mem[next_row];
      cur_u          <= down_q;
      left_q         <= older_mem[row];
      s1_px          <= in_px;
      s1_col         <= col;
      s1_row         <= row;
      s1_interior    <= interior;
      s1_last_col    <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && (s1_col != '0)) begin
      older_mem[s1_row] <= u;
      above             <= u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    red_sum = wgf_pkg::SUM_W'(above.red) + wgf_pkg::SUM_W'(down_q.red)
            + wgf_pkg::SUM_W'(left_q.red) + wgf_pkg::SUM_W'(s1_px.red);
    avg  = red_sum[wgf_pkg::SUM_W-1:2];
    fill = s1_interior && wgf_pkg::is_white(cur_u) && !wgf_pkg::is_white(above)
        && !wgf_pkg::is_white(down_q) && !wgf_pkg::is_white(left_q)
        && !wgf_pkg::is_white(s1_px);
    u = fill ? wgf_pkg::pixel_t'{red: avg, green: avg, blue: avg} : cur_u;

    load               = s1_move && (s1_col != '0);
    load_data.has_fill = s1_col != '0;
    load_data.has_self = s1_last_col;
    load_data.fill_px  = wgf_pkg::grounded(u);
    load_data.self_px  = wgf_pkg::grounded(s1_px);
    load_data.col      = s1_col;
    load_data.row      = wgf_pkg::OUT_ROW_W'(s1_row);
  end

endmodule

@@ src/wgf_out_buf.sv @@
// ----------------------------------------------------------------------------
// wgf_out_buf
// Output register: holds the one or two results of an item and shows them
// in order, end_of_run on the last one.
// ----------------------------------------------------------------------------
module wgf_out_buf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  wgf_pkg::load_t                load_data,
  output logic                          out_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wgf_pkg::pixel_t               out_px,
  output logic [wgf_pkg::COL_W-1:0]     out_col,
  output logic [wgf_pkg::OUT_ROW_W-1:0] out_row,
  output logic                          end_of_run
);

  logic                          has_a, has_b;
  wgf_pkg::pixel_t               a_px, b_px;
  logic [wgf_pkg::COL_W-1:0]     b_col;
  logic [wgf_pkg::OUT_ROW_W-1:0] row;

  assign out_valid  = has_a || has_b;
  assign end_of_run = has_a ^ has_b;
  assign out_free   = !out_valid || (out_ready && end_of_run);
  assign out_px     = has_a ? a_px : b_px;
  assign out_col    = has_a ? b_col - 1'b1 : b_col;
  assign out_row    = row;

  always_ff @(posedge clk) begin
    if (load) begin
      a_px  <= load_data.fill_px;
      b_px  <= load_data.self_px;
      b_col <= load_data.col;
      row   <= load_data.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_a <= 1'b0;
      has_b <= 1'b0;
    end else if (load) begin
      has_a <= load_data.has_fill;
      has_b <= load_data.has_self;
    end else if (out_valid && out_ready) begin
      if (has_a) begin
        has_a <= 1'b0;
      end else begin
        has_b <= 1'b0;
      end
    end
  end

endmodule

@@ src/white_gap_fill_filter.sv @@
// ----------------------------------------------------------------------------
// white_gap_fill_filter
// Fills isolated white pixels of a column-major RGB stream with grey and
// turns remaining white to black; results lag one column behind the input.
// Throughput: one item per cycle while the output is not held back; last-column
//   items give two results, which leave one after the other through the single output port while the input waits.
// Path: a pixel's result leaves once the item one column later has arrived and passed
//   the fill stage and the output register; a last-column pixel also leaves as
//   the second result of its own item.
// Reset: positions zero, image_width = image_height = 256; column stores
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module white_gap_fill_filter #(
  parameter int MAX_HEIGHT = wgf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // in_red, in_green, in_blue
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_red, out_green, out_blue, out_col, out_row, 2 bits zero
  output logic [47:0]                    m_axis_tdata,
  output logic                           m_axis_tlast,  // end_of_run
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wgf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_HEIGHT);

  logic [wgf_pkg::COL_W-1:0]     pos_col, out_col;
  logic [AW-1:0]                 pos_row, pos_next_row;
  logic                          pos_interior, pos_last_col, out_free, load, in_fire;
  wgf_pkg::load_t                load_data;
  wgf_pkg::pixel_t               in_px, out_px;
  logic [wgf_pkg::OUT_ROW_W-1:0] out_row;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign in_px.red    = s_axis_tdata[7:0];
  assign in_px.green  = s_axis_tdata[15:8];
  assign in_px.blue   = s_axis_tdata[23:16];
  assign m_axis_tdata = {2'b00, out_row, out_col, out_px.blue, out_px.green, out_px.red};

  wgf_position #(.MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_position (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .col      (pos_col),
    .row      (pos_row),
    .next_row (pos_next_row),
    .interior (pos_interior),
    .last_col (pos_last_col)
  );

  wgf_fill_core #(.MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_fill_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_px    (in_px),
    .col      (pos_col),
    .row      (pos_row),
    .next_row (pos_next_row),
    .interior (pos_interior),
    .last_col (pos_last_col),
    .out_free (out_free),
    .load     (load),
    .load_data(load_data)
  );

  wgf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (load_data),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_px    (out_px),
    .out_col   (out_col),
    .out_row   (out_row),
    .end_of_run(m_axis_tlast)
  );

  // input stalls only behind a held result
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  // a register write restarts the frame
  assert property (@(posedge clk) disable iff (rst)
                   cfg_we |=> (pos_col == '0) && (pos_row == '0))
    else $error("position not restarted after register write");

  // first of a result pair is always followed by the second
  assert property (@(posedge clk) disable iff (rst)
                   m_axis_tvalid && m_axis_tready && !m_axis_tlast
                   |=> m_axis_tvalid && m_axis_tlast)
    else $error("second result of a last-column item missing");

endmodule

@@ sim/gap_fill_checker.sv @@
// ----------------------------------------------------------------------------
// gap_fill_checker
// Watches the pixel, result and register channels of the white gap fill
// filter, keeps its own copy of the two column stores and predicts every
// finished pixel; results are compared in order against the predicted queue.
// ----------------------------------------------------------------------------
module gap_fill_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [23:0]                    in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [47:0]                    out_data,
  input  logic                           out_last,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wgf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 1024;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [9:0]  row;
    logic        last;
  } finished_px_t;

  finished_px_t                 finished_q[$];
  wgf_pkg::pixel_t              older_px[STORE_DEPTH];  // updated pixels, column two back
  wgf_pkg::pixel_t              newer_px[STORE_DEPTH];  // original pixels, previous column
  wgf_pkg::pixel_t              above_px;
  logic [wgf_pkg::WIDTH_W-1:0]  width_reg;
  logic [wgf_pkg::HEIGHT_W-1:0] height_reg;
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int                           mismatches;

  function automatic logic all_white(input wgf_pkg::pixel_t p);
    int unsigned s;
    s = p.red + p.green + p.blue;
    return s == 765;
  endfunction

  function automatic finished_px_t finish_px(input wgf_pkg::pixel_t p, input int unsigned c,
                                             input int unsigned r, input logic last);
    finished_px_t f;
    if (all_white(p)) p = '0;
    f.red   = p.red;
    f.green = p.green;
    f.blue  = p.blue;
    f.col   = c[11:0];
    f.row   = r[9:0];
    f.last  = last;
    return f;
  endfunction

  task automatic predict_fill(input wgf_pkg::pixel_t px);
    int unsigned     w, h, col, row, ri, avg;
    wgf_pkg::pixel_t u, up, dn, lf;
    logic            interior, last_col;
    w = (width_reg < 3) ? 3 : (width_reg > 4096) ? 4096 : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > 1024) ? 1024 : height_reg;
    col = col_pos;
    row = row_pos;
    ri = row % STORE_DEPTH;
    last_col = (col + 1 >= w);
    if (col >= 1) begin
      u = newer_px[ri];
      interior = (col >= 2) && (col + 1 <= w) && (row >= 1) && (row + 2 <= h);
      if (interior && all_white(u)) begin
        up = above_px;
        dn = newer_px[(row + 1) % STORE_DEPTH];
        lf = older_px[ri];
        if (!all_white(up) && !all_white(dn) && !all_white(lf) && !all_white(px)) begin
          avg = (up.red + dn.red + lf.red + px.red) / 4;
          u.red   = avg[7:0];
          u.green = avg[7:0];
          u.blue  = avg[7:0];
        end
      end
      older_px[ri] = u;
      above_px = u;
      finished_q = {finished_q, finish_px(u, col - 1, row, !last_col)};
    end
    newer_px[ri] = px;
    if (last_col) finished_q = {finished_q, finish_px(px, col, row, 1'b1)};
    if (row + 1 >= h) begin
      row_pos = 0;
      col_pos = last_col ? 0 : col + 1;
    end else begin
      row_pos = row + 1;
    end
  endtask

  always @(posedge clk) begin
    finished_px_t    got, want;
    wgf_pkg::pixel_t px;
    if (rst) begin
      finished_q.delete();
      width_reg = wgf_pkg::WIDTH_RESET;
      height_reg = wgf_pkg::HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      above_px = '0;
      mismatches = 0;
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wgf_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data[wgf_pkg::HEIGHT_W-1:0];
        // any register write restarts the frame
        col_pos = 0;
        row_pos = 0;
        above_px = '0;
      end
      if (in_valid && in_ready) begin
        px.red   = in_data[7:0];
        px.green = in_data[15:8];
        px.blue  = in_data[23:16];
        predict_fill(px);
      end
      if (out_valid && out_ready) begin
        got.red   = out_data[7:0];
        got.green = out_data[15:8];
        got.blue  = out_data[23:16];
        got.col   = out_data[35:24];
        got.row   = out_data[45:36];
        got.last  = out_last;
        if (finished_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item col=%0d row=%0d rgb=%0d,%0d,%0d", $realtime,
                     got.col, got.row, got.red, got.green, got.blue);
        end else begin
          want = finished_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: pixel mismatch exp col=%0d row=%0d rgb=%0d,%0d,%0d last=%0b",
                     $realtime, want.col, want.row, want.red, want.green, want.blue,
                     want.last);
              $display(" got col=%0d row=%0d rgb=%0d,%0d,%0d last=%0b",
                       got.col, got.row, got.red, got.green, got.blue, got.last);
            end
          end
        end
      end
      pending <= finished_q.size();
      fail_count <= mismatches;
    end
  end

endmodule

@@ sim/tb_white_gap_fill_filter.sv @@
// ----------------------------------------------------------------------------
// tb_white_gap_fill_filter
// Drives frames of RGB pixels through the white gap fill filter under several
// frame sizes and back-pressure patterns; gap_fill_checker predicts and
// compares the finished pixels.
// ----------------------------------------------------------------------------
module tb_white_gap_fill_filter;
  timeunit 1ns;
  timeprecision 1ps;

  // 3x3 frames, rows of column 0 first, 24'hRRGGBB
  localparam logic [23:0] DIRECTED_PX [18] = '{
    // center fill averages to 255, which is white again and goes out black
    24'h000000, 24'hFF0000, 24'h000000,
    24'hFF0102, 24'hFFFFFF, 24'hFF0304,
    24'h090909, 24'hFF0707, 24'hFFFFFF,
    // center fill to floor((20 + 30 + 10 + 41) / 4) = 25
    24'hFFFEFD, 24'h0A0000, 24'h010203,
    24'h140505, 24'hFFFFFF, 24'h1E0606,
    24'h00FF00, 24'h2900FF, 24'h0000FF
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [47:0]                    m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_we = 1'b0;
  wgf_pkg::cfg_reg_t              cfg_index = wgf_pkg::REG_IMAGE_WIDTH;
  logic [wgf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             pending;
  int                             fail_count;
  int                             idle_pct = 0;
  int                             stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  white_gap_fill_filter uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  gap_fill_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk)
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

  // mostly white and red-255 pixels so isolated gaps and white fills show up
  function automatic wgf_pkg::pixel_t random_pixel();
    wgf_pkg::pixel_t p;
    int              kind;
    kind = $urandom_range(0, 9);
    p = wgf_pkg::pixel_t'($urandom);
    if (kind < 4) p = '1;
    else if (kind < 6) p.red = 8'hFF;
    return p;
  endfunction

  task automatic send_pixel(input wgf_pkg::pixel_t px);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {px.blue, px.green, px.red};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // column-0 items leave nothing to wait for but may still be in flight
    repeat (16) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    cfg_we <= 1'b1;
    cfg_index <= wgf_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w[wgf_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= wgf_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h[wgf_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mode: 0 no idling, 1 sender idle, 2 receiver stall, 3 both
  task automatic run_frames(input int w, input int h, input int n, input int mode);
    idle_pct = (mode == 1) ? 53 : (mode == 3) ? 25 : 0;
    stall_pct <= (mode == 2) ? 53 : (mode == 3) ? 25 : 0;
    set_frame(w, h);
    repeat (n) send_pixel(random_pixel());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset frame size 256x256, column 0 results only
    repeat (280) send_pixel(random_pixel());
    drain();

    set_frame(3, 3);
    foreach (DIRECTED_PX[i]) send_pixel(wgf_pkg::pixel_t'(DIRECTED_PX[i]));
    drain();

    run_frames(0, 0, 120, 1);         // both clamp up to 3
    run_frames(5, 4, 160, 2);
    run_frames(4, 7, 160, 3);
    run_frames(8191, 2, 40, 0);       // 4096 x 3
    run_frames(6, 5, 120, 1);
    run_frames(3, 3, 100, 3);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
